@@ sv/c6502ex_pkg.sv @@
package c6502ex_pkg;

    // Status flag bit positions (NV1BDIZC)
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Reset values of the architectural registers
    localparam logic [7:0] RESET_STATUS = 8'h24;
    localparam logic [7:0] RESET_STACK  = 8'hFD;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = 53;
    localparam int OUT_TDATA_W = 56;

    // Decoded operation classes
    typedef enum logic [5:0] {
        OP_UNH, OP_NOP,
        OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY,
        OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY,
        OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_INC, OP_DEC,
        OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA,
        OP_INX, OP_INY, OP_DEX, OP_DEY, OP_BIT,
        OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS,
        OP_PHA, OP_PHP, OP_PLA, OP_PLP,
        OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED,
        OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ
    } t_op;

    // Architectural register set
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] idx_x;
        logic [7:0] idx_y;
        logic [7:0] status;
        logic [7:0] stack;
    } t_regs;

    // Side effects of one instruction
    typedef struct packed {
        logic [7:0] write_data;
        logic       write_enable;
        logic       push_enable;
        logic       pop_used;
        logic       branch_taken;
        logic       unhandled;
    } t_effects;

endpackage

@@ sv/c6502ex_decode.sv @@
module c6502ex_decode (
    input  logic [7:0]       i_opcode,
    output c6502ex_pkg::t_op o_op
);
    import c6502ex_pkg::*;

    // Opcode to operation class; everything not listed is unhandled
    always_comb begin
        unique case (i_opcode) inside
            8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: o_op = OP_ORA;
            8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: o_op = OP_AND;
            8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: o_op = OP_EOR;
            8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: o_op = OP_ADC;
            8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D:        o_op = OP_STA;
            8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: o_op = OP_LDA;
            8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: o_op = OP_CMP;
            8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: o_op = OP_SBC;
            8'h06, 8'h0E, 8'h16, 8'h1E: o_op = OP_ASL;
            8'h26, 8'h2E, 8'h36, 8'h3E: o_op = OP_ROL;
            8'h46, 8'h4E, 8'h56, 8'h5E: o_op = OP_LSR;
            8'h66, 8'h6E, 8'h76, 8'h7E: o_op = OP_ROR;
            8'hC6, 8'hCE, 8'hD6, 8'hDE: o_op = OP_DEC;
            8'hE6, 8'hEE, 8'hF6, 8'hFE: o_op = OP_INC;
            8'h86, 8'h8E, 8'h96:        o_op = OP_STX;
            8'h84, 8'h8C, 8'h94:        o_op = OP_STY;
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: o_op = OP_LDX;
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: o_op = OP_LDY;
            8'hC0, 8'hC4, 8'hCC:        o_op = OP_CPY;
            8'hE0, 8'hE4, 8'hEC:        o_op = OP_CPX;
            8'h24, 8'h2C:               o_op = OP_BIT;
            8'h08: o_op = OP_PHP;
            8'h28: o_op = OP_PLP;
            8'h48: o_op = OP_PHA;
            8'h68: o_op = OP_PLA;
            8'h0A: o_op = OP_ASLA;
            8'h2A: o_op = OP_ROLA;
            8'h4A: o_op = OP_LSRA;
            8'h6A: o_op = OP_RORA;
            8'h88: o_op = OP_DEY;
            8'hC8: o_op = OP_INY;
            8'hCA: o_op = OP_DEX;
            8'hE8: o_op = OP_INX;
            8'h8A: o_op = OP_TXA;
            8'h98: o_op = OP_TYA;
            8'hA8: o_op = OP_TAY;
            8'hAA: o_op = OP_TAX;
            8'h9A: o_op = OP_TXS;
            8'hBA: o_op = OP_TSX;
            8'hEA: o_op = OP_NOP;
            8'h18: o_op = OP_CLC;
            8'h38: o_op = OP_SEC;
            8'h58: o_op = OP_CLI;
            8'h78: o_op = OP_SEI;
            8'hB8: o_op = OP_CLV;
            8'hD8: o_op = OP_CLD;
            8'hF8: o_op = OP_SED;
            8'h10: o_op = OP_BPL;
            8'h30: o_op = OP_BMI;
            8'h50: o_op = OP_BVC;
            8'h70: o_op = OP_BVS;
            8'h90: o_op = OP_BCC;
            8'hB0: o_op = OP_BCS;
            8'hD0: o_op = OP_BNE;
            8'hF0: o_op = OP_BEQ;
            default: o_op = OP_UNH;
        endcase
    end

endmodule

@@ sv/c6502ex_alu.sv @@
module c6502ex_alu (
    input  c6502ex_pkg::t_op      i_op,
    input  logic [7:0]            i_operand,
    input  c6502ex_pkg::t_regs    i_regs,
    output c6502ex_pkg::t_regs    o_regs,
    output c6502ex_pkg::t_effects o_fx
);
    import c6502ex_pkg::*;

    logic [7:0] add_m;
    logic [8:0] sum;
    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    logic [7:0] mod_in;
    logic [7:0] mod_out;
    logic       mod_c;
    logic       cin;
    logic [7:0] nz_val;
    logic       nz_upd;

    assign cin = i_regs.status[FLAG_C];

    // Adder: SBC is ADC of the inverted operand
    assign add_m = (i_op == OP_SBC) ? ~i_operand : i_operand;
    assign sum   = {1'b0, i_regs.acc} + {1'b0, add_m} + {8'd0, cin};

    // Compare subtractor
    always_comb begin
        case (i_op)
            OP_CPX:  cmp_reg = i_regs.idx_x;
            OP_CPY:  cmp_reg = i_regs.idx_y;
            default: cmp_reg = i_regs.acc;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, i_operand};

    // Shift/rotate/inc/dec unit source
    always_comb begin
        case (i_op) inside
            OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA: mod_in = i_regs.acc;
            OP_INX, OP_DEX:                     mod_in = i_regs.idx_x;
            OP_INY, OP_DEY:                     mod_in = i_regs.idx_y;
            default:                            mod_in = i_operand;
        endcase
    end

    // Shift/rotate/inc/dec unit
    always_comb begin
        mod_c = cin;
        case (i_op) inside
            OP_ASL, OP_ASLA: begin
                mod_out = {mod_in[6:0], 1'b0};
                mod_c   = mod_in[7];
            end
            OP_ROL, OP_ROLA: begin
                mod_out = {mod_in[6:0], cin};
                mod_c   = mod_in[7];
            end
            OP_LSR, OP_LSRA: begin
                mod_out = {1'b0, mod_in[7:1]};
                mod_c   = mod_in[0];
            end
            OP_ROR, OP_RORA: begin
                mod_out = {cin, mod_in[7:1]};
                mod_c   = mod_in[0];
            end
            OP_INC, OP_INX, OP_INY: mod_out = mod_in + 8'd1;
            default:                mod_out = mod_in - 8'd1;
        endcase
    end

    // Register and flag update
    always_comb begin
        o_regs = i_regs;
        o_fx   = '0;
        nz_val = 8'd0;
        nz_upd = 1'b0;
        unique case (i_op)
            OP_ORA: begin o_regs.acc = i_regs.acc | i_operand; nz_upd = 1'b1; end
            OP_AND: begin o_regs.acc = i_regs.acc & i_operand; nz_upd = 1'b1; end
            OP_EOR: begin o_regs.acc = i_regs.acc ^ i_operand; nz_upd = 1'b1; end
            OP_ADC, OP_SBC: begin
                o_regs.acc = sum[7:0];
                o_regs.status[FLAG_C] = sum[8];
                o_regs.status[FLAG_V] = (i_regs.acc[7] ^ sum[7]) & (add_m[7] ^ sum[7]);
                nz_upd = 1'b1;
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                o_regs.status[FLAG_C] = ~cmp_diff[8];
                o_regs.status[FLAG_Z] = (cmp_diff[7:0] == 8'd0);
                o_regs.status[FLAG_N] = cmp_diff[7];
            end
            OP_LDA: begin o_regs.acc   = i_operand; nz_upd = 1'b1; end
            OP_LDX: begin o_regs.idx_x = i_operand; nz_upd = 1'b1; end
            OP_LDY: begin o_regs.idx_y = i_operand; nz_upd = 1'b1; end
            OP_STA: begin o_fx.write_data = i_regs.acc;   o_fx.write_enable = 1'b1; end
            OP_STX: begin o_fx.write_data = i_regs.idx_x; o_fx.write_enable = 1'b1; end
            OP_STY: begin o_fx.write_data = i_regs.idx_y; o_fx.write_enable = 1'b1; end
            OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
                o_fx.write_data = mod_out;
                o_fx.write_enable = 1'b1;
                o_regs.status[FLAG_C] = mod_c;
                nz_val = mod_out;
            end
            OP_INC, OP_DEC: begin
                o_fx.write_data = mod_out;
                o_fx.write_enable = 1'b1;
                nz_val = mod_out;
            end
            OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA: begin
                o_regs.acc = mod_out;
                o_regs.status[FLAG_C] = mod_c;
                nz_upd = 1'b1;
            end
            OP_INX, OP_DEX: begin o_regs.idx_x = mod_out; nz_upd = 1'b1; end
            OP_INY, OP_DEY: begin o_regs.idx_y = mod_out; nz_upd = 1'b1; end
            OP_BIT: begin
                o_regs.status[FLAG_Z] = ((i_regs.acc & i_operand) == 8'd0);
                o_regs.status[FLAG_V] = i_operand[6];
                o_regs.status[FLAG_N] = i_operand[7];
            end
            OP_TAX: begin o_regs.idx_x = i_regs.acc;   nz_upd = 1'b1; end
            OP_TAY: begin o_regs.idx_y = i_regs.acc;   nz_upd = 1'b1; end
            OP_TXA: begin o_regs.acc   = i_regs.idx_x; nz_upd = 1'b1; end
            OP_TYA: begin o_regs.acc   = i_regs.idx_y; nz_upd = 1'b1; end
            OP_TSX: begin o_regs.idx_x = i_regs.stack; nz_upd = 1'b1; end
            OP_TXS: o_regs.stack = i_regs.idx_x;
            OP_PHA: begin
                o_fx.write_data  = i_regs.acc;
                o_fx.push_enable = 1'b1;
                o_regs.stack     = i_regs.stack - 8'd1;
            end
            OP_PHP: begin
                o_fx.write_data  = i_regs.status | 8'h30;
                o_fx.push_enable = 1'b1;
                o_regs.stack     = i_regs.stack - 8'd1;
            end
            OP_PLA: begin
                o_regs.stack  = i_regs.stack + 8'd1;
                o_regs.acc    = i_operand;
                o_fx.pop_used = 1'b1;
                nz_upd        = 1'b1;
            end
            OP_PLP: begin
                o_regs.stack  = i_regs.stack + 8'd1;
                o_regs.status = (i_operand & 8'hEF) | 8'h20;
                o_fx.pop_used = 1'b1;
            end
            OP_CLC: o_regs.status[FLAG_C] = 1'b0;
            OP_SEC: o_regs.status[FLAG_C] = 1'b1;
            OP_CLI: o_regs.status[FLAG_I] = 1'b0;
            OP_SEI: o_regs.status[FLAG_I] = 1'b1;
            OP_CLV: o_regs.status[FLAG_V] = 1'b0;
            OP_CLD: o_regs.status[FLAG_D] = 1'b0;
            OP_SED: o_regs.status[FLAG_D] = 1'b1;
            OP_BPL: o_fx.branch_taken = ~i_regs.status[FLAG_N];
            OP_BMI: o_fx.branch_taken =  i_regs.status[FLAG_N];
            OP_BVC: o_fx.branch_taken = ~i_regs.status[FLAG_V];
            OP_BVS: o_fx.branch_taken =  i_regs.status[FLAG_V];
            OP_BCC: o_fx.branch_taken = ~i_regs.status[FLAG_C];
            OP_BCS: o_fx.branch_taken =  i_regs.status[FLAG_C];
            OP_BNE: o_fx.branch_taken = ~i_regs.status[FLAG_Z];
            OP_BEQ: o_fx.branch_taken =  i_regs.status[FLAG_Z];
            OP_NOP: ;
            default: o_fx.unhandled = 1'b1;
        endcase

        // N/Z from the register result, or from the memory write data
        if (nz_upd) begin
            case (i_op) inside
                OP_LDX, OP_INX, OP_DEX, OP_TAX, OP_TSX: nz_val = o_regs.idx_x;
                OP_LDY, OP_INY, OP_DEY, OP_TAY:         nz_val = o_regs.idx_y;
                default:                                nz_val = o_regs.acc;
            endcase
        end
        if (nz_upd || o_fx.write_enable && (i_op != OP_STA) && (i_op != OP_STX)
            && (i_op != OP_STY)) begin
            o_regs.status[FLAG_Z] = (nz_val == 8'd0);
            o_regs.status[FLAG_N] = nz_val[7];
        end
    end

endmodule

@@ sv/cpu_6502_execute_datapath.sv @@
// 6502 execute datapath (binary mode): A, X, Y, P and S plus one instruction per request.
// Stages: the decode register holds the accepted instruction, then the result register
// holds its ALU result. Throughput: one instruction per cycle while the output is not stalled;
// the execute stage reads the registers written by the previous instruction at the same
// edge that registered its result.
// Reset (synchronous, active low): A = X = Y = 0, P = 0x24, S = 0xFD, both stages empty.
module cpu_6502_execute_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // opcode[7:0], operand_byte[15:8]
    input  logic [c6502ex_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // acc_out[7:0], index_x_out[15:8], index_y_out[23:16], status_out[31:24],
    // stack_out[39:32], write_data[47:40], write_enable[48], push_enable[49],
    // pop_used[50], branch_taken[51], unhandled[52], zero pad[55:53]
    output logic [c6502ex_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import c6502ex_pkg::*;

    t_op      dec_op;
    t_regs    alu_regs;
    t_effects alu_fx;
    logic     advance;

    // Decode stage registers
    logic       r_in_valid;
    t_op        r_op;
    logic [7:0] r_operand;

    // Architectural state
    t_regs      r_regs;

    // Result stage registers
    logic       r_out_valid;
    t_regs      r_out_regs;
    t_effects   r_out_fx;

    c6502ex_decode u_decode (
        .i_opcode (i_s_axis_tdata[7:0]),
        .o_op     (dec_op)
    );

    c6502ex_alu u_alu (
        .i_op      (r_op),
        .i_operand (r_operand),
        .i_regs    (r_regs),
        .o_regs    (alu_regs),
        .o_fx      (alu_fx)
    );

    // Handshake: result stage frees when empty or taken
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_regs.acc     <= 8'd0;
            r_regs.idx_x   <= 8'd0;
            r_regs.idx_y   <= 8'd0;
            r_regs.status  <= RESET_STATUS;
            r_regs.stack   <= RESET_STACK;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_regs <= alu_regs;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_op      <= dec_op;
            r_operand <= i_s_axis_tdata[15:8];
        end
        if (advance && r_in_valid) begin
            r_out_regs <= alu_regs;
            r_out_fx   <= alu_fx;
        end
    end

    // Output packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                              r_out_fx.unhandled, r_out_fx.branch_taken,
                              r_out_fx.pop_used, r_out_fx.push_enable,
                              r_out_fx.write_enable, r_out_fx.write_data,
                              r_out_regs.stack, r_out_regs.status,
                              r_out_regs.idx_y, r_out_regs.idx_x, r_out_regs.acc};

    // State only moves when an instruction leaves the decode stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(advance && r_in_valid) |-> $stable(r_regs))
        else $error("architectural state changed without an executed instruction");

    // Unhandled opcodes have no side effects
    a_unh_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fx.unhandled |->
            !r_out_fx.write_enable && !r_out_fx.push_enable && !r_out_fx.pop_used
            && !r_out_fx.branch_taken && (r_out_fx.write_data == 8'd0))
        else $error("unhandled opcode produced a side effect");

    // A store and a push never come from the same instruction
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_fx.write_enable && r_out_fx.push_enable))
        else $error("store and push asserted together");

    // The unused status bit stays set
    a_unused_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.status[FLAG_U])
        else $error("status bit 5 cleared");

endmodule
